// ===== rtl/lens_undistort_homography_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the lens undistortion / homography core
// Shared helpers that wrap concurrent assertions with the house clocking.
// ----------------------------------------------------------------------------
`ifndef LENS_UNDISTORT_HOMOGRAPHY_CORE_ASSERT_SVH
`define LENS_UNDISTORT_HOMOGRAPHY_CORE_ASSERT_SVH

// same-cycle implication
`define LUH_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("luh assertion failed");

// next-cycle implication
`define LUH_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("luh assertion failed");

`endif

// ===== rtl/luh_pkg.sv =====
// ----------------------------------------------------------------------------
// luh_pkg
// Types, constants and the microprogram of the undistortion/homography core.
// ----------------------------------------------------------------------------
package luh_pkg;

   // defaults for top-level parameters
   localparam int DEF_ITERATIONS = 20;
   localparam int DEF_COEF_WIDTH = 48;

   // fixed-point limits, Q32.32
   localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] FX_ONE = 64'h0000_0001_0000_0000;

   // stores
   localparam int COEF_DEPTH = 18;
   localparam int COEF_AW = $clog2(COEF_DEPTH);
   localparam int TMP_DEPTH = 16;
   localparam int TMP_AW = $clog2(TMP_DEPTH);

   // microprogram
   localparam int PC_W = 6;
   localparam logic [PC_W-1:0] PROG_LEN = 6'd56;
   localparam logic [PC_W-1:0] LOOP_START = 6'd8;

   // result status codes
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_DIVZERO = 2'd1;
   localparam logic [1:0] ST_SAT = 2'd2;

   typedef enum logic [3:0] {
      OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
      OP_LDX, OP_LDY, OP_OUTX, OP_OUTY, OP_LOOP
   } luh_op_type;

   // operand sources: coefficient entries, temporaries, constant one
   localparam logic [5:0] SRC_CX = 6'd0;
   localparam logic [5:0] SRC_CY = 6'd1;
   localparam logic [5:0] SRC_FX = 6'd2;
   localparam logic [5:0] SRC_FY = 6'd3;
   localparam logic [5:0] SRC_K1 = 6'd4;
   localparam logic [5:0] SRC_K2 = 6'd5;
   localparam logic [5:0] SRC_P1 = 6'd6;
   localparam logic [5:0] SRC_P2 = 6'd7;
   localparam logic [5:0] SRC_K3 = 6'd8;
   localparam logic [5:0] SRC_H00 = 6'd9;
   localparam logic [5:0] SRC_H01 = 6'd10;
   localparam logic [5:0] SRC_H02 = 6'd11;
   localparam logic [5:0] SRC_H10 = 6'd12;
   localparam logic [5:0] SRC_H11 = 6'd13;
   localparam logic [5:0] SRC_H12 = 6'd14;
   localparam logic [5:0] SRC_H20 = 6'd15;
   localparam logic [5:0] SRC_H21 = 6'd16;
   localparam logic [5:0] SRC_H22 = 6'd17;
   localparam logic [5:0] SRC_ONE = 6'b11_0000;

   localparam logic [1:0] KIND_TMP = 2'b10;
   localparam logic [1:0] KIND_ONE = 2'b11;

   // temporaries
   localparam logic [3:0] T_XD0 = 4'd0;
   localparam logic [3:0] T_XD1 = 4'd1;
   localparam logic [3:0] T_X0 = 4'd2;
   localparam logic [3:0] T_X1 = 4'd3;
   localparam logic [3:0] T_SQ0 = 4'd4;
   localparam logic [3:0] T_SQ1 = 4'd5;
   localparam logic [3:0] T_R2 = 4'd6;
   localparam logic [3:0] T_R4 = 4'd7;
   localparam logic [3:0] T_R6 = 4'd8;
   localparam logic [3:0] T_KR = 4'd9;
   localparam logic [3:0] T_PXY = 4'd10;
   localparam logic [3:0] T_TWOXY = 4'd11;
   localparam logic [3:0] T_D0 = 4'd12;
   localparam logic [3:0] T_D1 = 4'd13;
   localparam logic [3:0] T_A = 4'd14;
   localparam logic [3:0] T_B = 4'd15;

   typedef struct packed {
      luh_op_type op;
      logic [3:0] dst;
      logic [5:0] src_a;
      logic [5:0] src_b;
   } luh_uop_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic coef_wr;
      logic go;
      luh_uop_type uop;
   } luh_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic done;
      logic zdiv;
   } luh_sts_type;

   function automatic logic [5:0] st(input logic [3:0] t);
      return {KIND_TMP, t};
   endfunction

   function automatic luh_uop_type mk(input luh_op_type op, input logic [3:0] d,
                                      input logic [5:0] a, input logic [5:0] b);
      luh_uop_type u;
      u.op = op;
      u.dst = d;
      u.src_a = a;
      u.src_b = b;
      return u;
   endfunction

   // microprogram: normalize, iterate, reproject, homography
   function automatic luh_uop_type luh_prog(input logic [PC_W-1:0] pc);
      case (pc)
         6'd0: return mk(OP_LDX, T_A, SRC_ONE, SRC_ONE);
         6'd1: return mk(OP_LDY, T_B, SRC_ONE, SRC_ONE);
         6'd2: return mk(OP_SUB, T_A, st(T_A), SRC_CX);
         6'd3: return mk(OP_DIV, T_XD0, st(T_A), SRC_FX);
         6'd4: return mk(OP_SUB, T_B, st(T_B), SRC_CY);
         6'd5: return mk(OP_DIV, T_XD1, st(T_B), SRC_FY);
         6'd6: return mk(OP_MOV, T_X0, st(T_XD0), SRC_ONE);
         6'd7: return mk(OP_MOV, T_X1, st(T_XD1), SRC_ONE);
         // iteration body
         6'd8: return mk(OP_MUL, T_SQ0, st(T_X0), st(T_X0));
         6'd9: return mk(OP_MUL, T_SQ1, st(T_X1), st(T_X1));
         6'd10: return mk(OP_ADD, T_R2, st(T_SQ0), st(T_SQ1));
         6'd11: return mk(OP_MUL, T_R4, st(T_R2), st(T_R2));
         6'd12: return mk(OP_MUL, T_R6, st(T_R4), st(T_R2));
         6'd13: return mk(OP_MUL, T_A, SRC_K1, st(T_R2));
         6'd14: return mk(OP_ADD, T_KR, SRC_ONE, st(T_A));
         6'd15: return mk(OP_MUL, T_A, SRC_K2, st(T_R4));
         6'd16: return mk(OP_MUL, T_B, SRC_K3, st(T_R6));
         6'd17: return mk(OP_ADD, T_A, st(T_A), st(T_B));
         6'd18: return mk(OP_ADD, T_KR, st(T_KR), st(T_A));
         6'd19: return mk(OP_MUL, T_PXY, st(T_X0), st(T_X1));
         6'd20: return mk(OP_ADD, T_TWOXY, st(T_PXY), st(T_PXY));
         6'd21: return mk(OP_ADD, T_A, st(T_SQ0), st(T_SQ0));
         6'd22: return mk(OP_ADD, T_A, st(T_R2), st(T_A));
         6'd23: return mk(OP_MUL, T_A, SRC_P2, st(T_A));
         6'd24: return mk(OP_MUL, T_D0, SRC_P1, st(T_TWOXY));
         6'd25: return mk(OP_ADD, T_D0, st(T_D0), st(T_A));
         6'd26: return mk(OP_ADD, T_A, st(T_SQ1), st(T_SQ1));
         6'd27: return mk(OP_ADD, T_A, st(T_R2), st(T_A));
         6'd28: return mk(OP_MUL, T_D1, SRC_P1, st(T_A));
         6'd29: return mk(OP_MUL, T_A, SRC_P2, st(T_TWOXY));
         6'd30: return mk(OP_ADD, T_D1, st(T_D1), st(T_A));
         6'd31: return mk(OP_SUB, T_A, st(T_XD0), st(T_D0));
         6'd32: return mk(OP_DIV, T_X0, st(T_A), st(T_KR));
         6'd33: return mk(OP_SUB, T_A, st(T_XD1), st(T_D1));
         6'd34: return mk(OP_DIV, T_X1, st(T_A), st(T_KR));
         6'd35: return mk(OP_LOOP, T_A, SRC_ONE, SRC_ONE);
         // reproject to pixels: u in SQ0, v in SQ1
         6'd36: return mk(OP_MUL, T_SQ0, st(T_X0), SRC_FX);
         6'd37: return mk(OP_ADD, T_SQ0, st(T_SQ0), SRC_CX);
         6'd38: return mk(OP_MUL, T_SQ1, st(T_X1), SRC_FY);
         6'd39: return mk(OP_ADD, T_SQ1, st(T_SQ1), SRC_CY);
         // projective scale in R2
         6'd40: return mk(OP_MUL, T_A, SRC_H20, st(T_SQ0));
         6'd41: return mk(OP_MUL, T_B, SRC_H21, st(T_SQ1));
         6'd42: return mk(OP_ADD, T_A, st(T_A), st(T_B));
         6'd43: return mk(OP_ADD, T_R2, st(T_A), SRC_H22);
         // numerators in R4 and R6
         6'd44: return mk(OP_MUL, T_A, SRC_H00, st(T_SQ0));
         6'd45: return mk(OP_MUL, T_B, SRC_H01, st(T_SQ1));
         6'd46: return mk(OP_ADD, T_A, st(T_A), st(T_B));
         6'd47: return mk(OP_ADD, T_R4, st(T_A), SRC_H02);
         6'd48: return mk(OP_MUL, T_A, SRC_H10, st(T_SQ0));
         6'd49: return mk(OP_MUL, T_B, SRC_H11, st(T_SQ1));
         6'd50: return mk(OP_ADD, T_A, st(T_A), st(T_B));
         6'd51: return mk(OP_ADD, T_R6, st(T_A), SRC_H12);
         6'd52: return mk(OP_DIV, T_A, st(T_R4), st(T_R2));
         6'd53: return mk(OP_OUTX, T_A, st(T_A), SRC_ONE);
         6'd54: return mk(OP_DIV, T_A, st(T_R6), st(T_R2));
         6'd55: return mk(OP_OUTY, T_A, st(T_A), SRC_ONE);
         default: return mk(OP_OUTY, T_A, st(T_A), SRC_ONE);
      endcase
   endfunction

endpackage

// ===== rtl/luh_ram.sv =====
// ----------------------------------------------------------------------------
// luh_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module luh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr_a,
   input  logic [ADDR_WIDTH-1:0] rd_addr_b,
   output logic [WIDTH-1:0]      rd_data_a,
   output logic [WIDTH-1:0]      rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // write and registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== rtl/luh_mul.sv =====
// ----------------------------------------------------------------------------
// luh_mul
// Q32.32 multiplier: four 32x32 partial products, then round and saturate.
// ----------------------------------------------------------------------------
module luh_mul import luh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] result,
   output logic        sat
);

   logic         busy_ff;
   logic [2:0]   step_ff;
   logic         neg_ff;
   logic [63:0]  ma_ff;
   logic [63:0]  mb_ff;
   logic [127:0] acc_ff;

   logic [31:0]  part_a;
   logic [31:0]  part_b;
   logic [63:0]  pp;
   logic [127:0] pp_sh;
   logic [127:0] rnd;
   logic [63:0]  mag;

   // partial product for this step
   always_comb begin
      part_a = step_ff[0] ? ma_ff[63:32] : ma_ff[31:0];
      part_b = step_ff[1] ? mb_ff[63:32] : mb_ff[31:0];
      pp = 64'(part_a) * 64'(part_b);
      case (step_ff)
         3'd0:    pp_sh = {64'd0, pp};
         3'd3:    pp_sh = {pp, 64'd0};
         default: pp_sh = {32'd0, pp, 32'd0};
      endcase
   end

   // round to nearest, saturate on overflow
   always_comb begin
      rnd = acc_ff + 128'h8000_0000;
      sat = |rnd[127:95];
      mag = sat ? MAX64 : {1'b0, rnd[94:32]};
      result = neg_ff ? (64'd0 - mag) : mag;
      done = busy_ff && (step_ff == 3'd4);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 3'd0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= 3'd0;
      end else if (busy_ff) begin
         if (step_ff == 3'd4) begin
            busy_ff <= 1'b0;
         end else begin
            step_ff <= step_ff + 3'd1;
         end
      end
   end

   // operand and accumulator registers
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= op_a[63] ^ op_b[63];
         ma_ff <= op_a[63] ? (64'd0 - op_a) : op_a;
         mb_ff <= op_b[63] ? (64'd0 - op_b) : op_b;
         acc_ff <= 128'd0;
      end else if (busy_ff && step_ff != 3'd4) begin
         acc_ff <= acc_ff + pp_sh;
      end
   end

endmodule

// ===== rtl/luh_div.sv =====
// ----------------------------------------------------------------------------
// luh_div
// Q32.32 divider: restoring, one quotient bit per cycle over 96 steps.
// ----------------------------------------------------------------------------
module luh_div import luh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] result,
   output logic        sat
);

   localparam logic [6:0] STEPS = 7'd96;

   logic        busy_ff;
   logic [6:0]  cnt_ff;
   logic        neg_ff;
   logic        over_ff;
   logic [63:0] mb_ff;
   logic [95:0] dvd_ff;
   logic [63:0] rem_ff;
   logic [63:0] q_ff;

   logic [64:0] rem_sh;
   logic        fits;
   logic        half;
   logic [64:0] q_rnd;
   logic [63:0] mag;

   // one restoring step
   always_comb begin
      rem_sh = {rem_ff, dvd_ff[95]};
      fits = rem_sh >= {1'b0, mb_ff};
   end

   // round half away, saturate
   always_comb begin
      half = rem_ff >= (mb_ff - rem_ff);
      q_rnd = {1'b0, q_ff} + 65'(half);
      sat = over_ff || (q_rnd > {1'b0, MAX64});
      mag = sat ? MAX64 : q_rnd[63:0];
      result = neg_ff ? (64'd0 - mag) : mag;
      done = busy_ff && (cnt_ff == STEPS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= 7'd0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff <= 7'd0;
      end else if (busy_ff) begin
         if (cnt_ff == STEPS) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= op_a[63] ^ op_b[63];
         mb_ff <= op_b[63] ? (64'd0 - op_b) : op_b;
         dvd_ff <= {(op_a[63] ? (64'd0 - op_a) : op_a), 32'd0};
         rem_ff <= 64'd0;
         q_ff <= 64'd0;
         over_ff <= 1'b0;
      end else if (busy_ff && cnt_ff != STEPS) begin
         dvd_ff <= {dvd_ff[94:0], 1'b0};
         if (q_ff[63:62] != 2'b00) begin
            over_ff <= 1'b1;
         end
         if (fits) begin
            rem_ff <= 64'(rem_sh - {1'b0, mb_ff});
            q_ff <= {q_ff[62:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[63:0];
            q_ff <= {q_ff[62:0], 1'b0};
         end
      end
   end

endmodule

// ===== rtl/luh_datapath.sv =====
// ----------------------------------------------------------------------------
// luh_datapath
// Coefficient store, temporaries, adder, multiplier, divider and result regs.
// ----------------------------------------------------------------------------
module luh_datapath import luh_pkg::*; #(
   parameter int COEFFICIENT_WIDTH = DEF_COEF_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  luh_cmd_type        cmd,
   input  logic [4:0]         coefficient_index,
   input  logic signed [47:0] coefficient_value,
   input  logic signed [31:0] pixel_x,
   input  logic signed [31:0] pixel_y,
   output luh_sts_type        sts,
   output logic signed [31:0] world_x,
   output logic signed [31:0] world_y,
   output logic [1:0]         status
);

   localparam logic signed [64:0] POS_LIM = 65'sh0_7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [64:0] NEG_LIM = -POS_LIM;

   logic [COEF_DEPTH-1:0] coef_valid_ff;
   logic [1:0]  kind_a_ff;
   logic [1:0]  kind_b_ff;
   logic        cv_a_ff;
   logic        cv_b_ff;
   logic [31:0] px_ff;
   logic [31:0] py_ff;
   logic        sat_ff;
   logic [3:0]  dst_ff;
   logic [31:0] world_x_ff;
   logic [31:0] world_y_ff;
   logic [1:0]  status_ff;

   logic                         coef_wr_en;
   logic [COEF_DEPTH-1:0]        coef_valid_in;
   logic [COEFFICIENT_WIDTH-1:0] coef_rd_a;
   logic [COEFFICIENT_WIDTH-1:0] coef_rd_b;
   logic [63:0] tmp_rd_a;
   logic [63:0] tmp_rd_b;
   logic [63:0] opa;
   logic [63:0] opb;
   logic        cv_a_in;
   logic        cv_b_in;

   logic signed [64:0] sum;
   logic [63:0] simple_res;
   logic        simple_sat;
   logic        simple_wr;
   logic        is_div;
   logic        is_zero;

   logic        mul_start;
   logic        mul_done;
   logic [63:0] mul_res;
   logic        mul_sat;
   logic        div_start;
   logic        div_done;
   logic [63:0] div_res;
   logic        div_sat;

   logic [63:0] q_mag;
   logic [48:0] q_r;
   logic [48:0] q_c;
   logic        q_sat;
   logic [31:0] q_val;

   logic        tmp_wr_en;
   logic [63:0] tmp_wr_data;
   logic [3:0]  tmp_wr_addr;

   function automatic logic [63:0] pick(input logic [1:0] kind, input logic cv,
                                        input logic [COEFFICIENT_WIDTH-1:0] coef,
                                        input logic [63:0] tmp);
      logic signed [COEFFICIENT_WIDTH-1:0] cs;
      cs = coef;
      if (!kind[1]) begin
         return cv ? 64'(cs) : 64'd0;
      end else if (kind == KIND_TMP) begin
         return tmp;
      end
      return FX_ONE;
   endfunction

   // coefficient store with valid bits: an unwritten entry reads zero
   assign coef_wr_en = cmd.coef_wr && (coefficient_index < 5'(COEF_DEPTH));

   always_comb begin
      coef_valid_in = coef_valid_ff;
      if (coef_wr_en) begin
         coef_valid_in[coefficient_index] = 1'b1;
      end
      cv_a_in = 1'b0;
      cv_b_in = 1'b0;
      if (cmd.uop.src_a[4:0] < 5'(COEF_DEPTH)) begin
         cv_a_in = coef_valid_ff[cmd.uop.src_a[4:0]];
      end
      if (cmd.uop.src_b[4:0] < 5'(COEF_DEPTH)) begin
         cv_b_in = coef_valid_ff[cmd.uop.src_b[4:0]];
      end
   end

   luh_ram #(
      .WIDTH (COEFFICIENT_WIDTH),
      .DEPTH (COEF_DEPTH)
   ) u_coef_ram (
      .clock     (clock),
      .wr_en     (coef_wr_en),
      .wr_addr   (COEF_AW'(coefficient_index)),
      .wr_data   (COEFFICIENT_WIDTH'($unsigned(coefficient_value))),
      .rd_addr_a (COEF_AW'(cmd.uop.src_a[4:0])),
      .rd_addr_b (COEF_AW'(cmd.uop.src_b[4:0])),
      .rd_data_a (coef_rd_a),
      .rd_data_b (coef_rd_b)
   );

   luh_ram #(
      .WIDTH (64),
      .DEPTH (TMP_DEPTH)
   ) u_tmp_ram (
      .clock     (clock),
      .wr_en     (tmp_wr_en),
      .wr_addr   (tmp_wr_addr),
      .wr_data   (tmp_wr_data),
      .rd_addr_a (TMP_AW'(cmd.uop.src_a[3:0])),
      .rd_addr_b (TMP_AW'(cmd.uop.src_b[3:0])),
      .rd_data_a (tmp_rd_a),
      .rd_data_b (tmp_rd_b)
   );

   // operand select, aligned with the registered reads
   assign opa = pick(kind_a_ff, cv_a_ff, coef_rd_a, tmp_rd_a);
   assign opb = pick(kind_b_ff, cv_b_ff, coef_rd_b, tmp_rd_b);

   // combinational ops: saturating add/sub, moves, pixel loads
   always_comb begin
      if (cmd.uop.op == OP_SUB) begin
         sum = $signed({opa[63], opa}) - $signed({opb[63], opb});
      end else begin
         sum = $signed({opa[63], opa}) + $signed({opb[63], opb});
      end
      simple_sat = 1'b0;
      simple_wr = 1'b1;
      case (cmd.uop.op)
         OP_ADD, OP_SUB: begin
            if (sum > POS_LIM) begin
               simple_res = MAX64;
               simple_sat = 1'b1;
            end else if (sum < NEG_LIM) begin
               simple_res = 64'(NEG_LIM);
               simple_sat = 1'b1;
            end else begin
               simple_res = sum[63:0];
            end
         end
         OP_LDX: simple_res = {{16{px_ff[31]}}, px_ff, 16'd0};
         OP_LDY: simple_res = {{16{py_ff[31]}}, py_ff, 16'd0};
         OP_MOV: simple_res = opa;
         default: begin
            simple_res = opa;
            simple_wr = 1'b0;
         end
      endcase
      is_div = cmd.uop.op == OP_DIV;
      is_zero = opb == 64'd0;
   end

   assign mul_start = cmd.go && (cmd.uop.op == OP_MUL);
   assign div_start = cmd.go && is_div && !is_zero;

   luh_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (opa),
      .op_b   (opb),
      .done   (mul_done),
      .result (mul_res),
      .sat    (mul_sat)
   );

   luh_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .op_a   (opa),
      .op_b   (opb),
      .done   (div_done),
      .result (div_res),
      .sat    (div_sat)
   );

   // round Q32.32 to Q16.16 with 32-bit saturation
   always_comb begin
      q_mag = opa[63] ? (64'd0 - opa) : opa;
      q_r = {1'b0, q_mag[63:16]} + 49'(q_mag[15]);
      q_sat = 1'b0;
      q_c = q_r;
      if (!opa[63] && q_r > 49'h0_7FFF_FFFF) begin
         q_sat = 1'b1;
         q_c = 49'h0_7FFF_FFFF;
      end
      if (opa[63] && q_r > 49'h0_8000_0000) begin
         q_sat = 1'b1;
         q_c = 49'h0_8000_0000;
      end
      q_val = opa[63] ? 32'(49'd0 - q_c) : q_c[31:0];
   end

   // temporaries write port
   always_comb begin
      tmp_wr_en = (cmd.go && simple_wr) || mul_done || div_done;
      tmp_wr_addr = cmd.go ? cmd.uop.dst : dst_ff;
      if (mul_done) begin
         tmp_wr_data = mul_res;
      end else if (div_done) begin
         tmp_wr_data = div_res;
      end else begin
         tmp_wr_data = simple_res;
      end
   end

   // status back to the controller
   always_comb begin
      sts.zdiv = cmd.go && is_div && is_zero;
      sts.done = (cmd.go && cmd.uop.op != OP_MUL && (!is_div || is_zero))
                 || mul_done || div_done;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_valid_ff <= '0;
         sat_ff <= 1'b0;
      end else begin
         coef_valid_ff <= coef_valid_in;
         if (cmd.accept) begin
            sat_ff <= 1'b0;
         end else if ((cmd.go && simple_sat) || (mul_done && mul_sat)
                      || (div_done && div_sat)
                      || (cmd.go && cmd.uop.op == OP_OUTX && q_sat)) begin
            sat_ff <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_a_ff <= cmd.uop.src_a[5:4];
      kind_b_ff <= cmd.uop.src_b[5:4];
      cv_a_ff <= cv_a_in;
      cv_b_ff <= cv_b_in;
      if (cmd.accept) begin
         px_ff <= pixel_x;
         py_ff <= pixel_y;
      end
      if (cmd.go) begin
         dst_ff <= cmd.uop.dst;
      end
      if (sts.zdiv) begin
         world_x_ff <= 32'd0;
         world_y_ff <= 32'd0;
         status_ff <= ST_DIVZERO;
      end else if (cmd.go && cmd.uop.op == OP_OUTX) begin
         world_x_ff <= q_val;
      end else if (cmd.go && cmd.uop.op == OP_OUTY) begin
         world_y_ff <= q_val;
         status_ff <= (sat_ff || q_sat) ? ST_SAT : ST_OK;
      end
   end

   assign world_x = world_x_ff;
   assign world_y = world_y_ff;
   assign status = status_ff;

endmodule

// ===== rtl/luh_ctrl.sv =====
// ----------------------------------------------------------------------------
// luh_ctrl
// Sequencer: handshakes, microprogram counter and iteration loop.
// ----------------------------------------------------------------------------
`include "lens_undistort_homography_core_assert.svh"

module luh_ctrl import luh_pkg::*; #(
   parameter int UNDISTORT_ITERATIONS = DEF_ITERATIONS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  luh_sts_type sts,
   output luh_cmd_type cmd
);

   localparam int IW = $clog2(UNDISTORT_ITERATIONS + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_FETCH, S_START, S_WAIT, S_RESP
   } state_type;

   state_type        state_ff;
   logic [PC_W-1:0]  pc_ff;
   logic [IW-1:0]    iter_ff;
   luh_uop_type      uop;

   assign uop = luh_prog(pc_ff);

   // commands
   always_comb begin
      cmd.accept = (state_ff == S_IDLE) && req_valid && !req_operation;
      cmd.coef_wr = (state_ff == S_IDLE) && req_valid && req_operation;
      cmd.go = state_ff == S_START;
      cmd.uop = uop;
      req_stall = state_ff != S_IDLE;
      rsp_valid = state_ff == S_RESP;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff <= '0;
         iter_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_operation) begin
                  pc_ff <= '0;
                  iter_ff <= '0;
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               if (uop.op == OP_LOOP) begin
                  if (iter_ff == IW'(UNDISTORT_ITERATIONS - 1)) begin
                     iter_ff <= '0;
                     pc_ff <= pc_ff + 1'b1;
                  end else begin
                     iter_ff <= iter_ff + 1'b1;
                     pc_ff <= LOOP_START;
                  end
               end else begin
                  state_ff <= S_START;
               end
            end
            S_START, S_WAIT: begin
               if (sts.done) begin
                  if (sts.zdiv || uop.op == OP_OUTY) begin
                     state_ff <= S_RESP;
                  end else begin
                     pc_ff <= pc_ff + 1'b1;
                     state_ff <= S_FETCH;
                  end
               end else begin
                  state_ff <= S_WAIT;
               end
            end
            S_RESP: begin
               if (!rsp_stall) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // checks
   `LUH_ASSERT_IMP(a_done_only_exec, clock, reset, (state_ff == S_IDLE || state_ff == S_FETCH || state_ff == S_RESP), !sts.done)
   `LUH_ASSERT_IMP(a_pc_in_range, clock, reset, 1'b1, pc_ff < PROG_LEN)
   `LUH_ASSERT_NEXT(a_accept_starts, clock, reset, cmd.accept, (state_ff == S_FETCH && pc_ff == '0))

endmodule

// ===== rtl/lens_undistort_homography_core.sv =====
// ----------------------------------------------------------------------------
// lens_undistort_homography_core
// Pixel point to world plane: lens undistortion then homography, fixed point.
// ----------------------------------------------------------------------------
// Flow: rsp_valid rises once the microprogram for an accepted transform beat
//   has run. A nonzero divide uses the 96-step serial divider, a multiply four
//   partial products. req_stall stays high until the result is taken, as
//   rsp_stall allows, so a further transform waits for it; a coefficient
//   write beat gives no result.
// Reset: synchronous, active high; the coefficient store reads zero after it.
// ----------------------------------------------------------------------------
module lens_undistort_homography_core import luh_pkg::*; #(
   parameter int UNDISTORT_ITERATIONS = DEF_ITERATIONS,
   parameter int COEFFICIENT_WIDTH = DEF_COEF_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic [4:0]         req_coefficient_index,
   input  logic signed [47:0] req_coefficient_value,
   input  logic signed [31:0] req_pixel_x,
   input  logic signed [31:0] req_pixel_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_world_x,
   output logic signed [31:0] rsp_world_y,
   output logic [1:0]         rsp_status
);

   luh_cmd_type cmd;
   luh_sts_type sts;

   luh_ctrl #(
      .UNDISTORT_ITERATIONS (UNDISTORT_ITERATIONS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .sts           (sts),
      .cmd           (cmd)
   );

   luh_datapath #(
      .COEFFICIENT_WIDTH (COEFFICIENT_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .coefficient_index (req_coefficient_index),
      .coefficient_value (req_coefficient_value),
      .pixel_x           (req_pixel_x),
      .pixel_y           (req_pixel_y),
      .sts               (sts),
      .world_x           (rsp_world_x),
      .world_y           (rsp_world_y),
      .status            (rsp_status)
   );

endmodule

// ===== verif/lens_undistort_homography_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lens_undistort_homography_core_tb
// Self-checking bench: fills the coefficient store, sends pixel points and
// compares each world point and status against a fixed-point predictor.
// ----------------------------------------------------------------------------
module lens_undistort_homography_core_tb;
   import luh_pkg::*;

   localparam int ITERS = DEF_ITERATIONS;
   localparam int DEPTH = COEF_DEPTH;
   localparam int WATCHDOG_LIMIT = 60000;
   localparam longint MAXV = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint ONE = 64'sh0000_0001_0000_0000;
   localparam logic OPC_XFORM = 1'b0;
   localparam logic OPC_WRITE = 1'b1;
   localparam logic [4:0] IX_CX = 5'd0, IX_CY = 5'd1, IX_FX = 5'd2, IX_FY = 5'd3;
   localparam logic [4:0] IX_K1 = 5'd4, IX_K3 = 5'd8, IX_H00 = 5'd9, IX_H11 = 5'd13;
   localparam logic [4:0] IX_H22 = 5'd17;

   typedef struct packed {
      logic signed [31:0] wx;
      logic signed [31:0] wy;
      logic [1:0]         status;
   } world_pt_t;

   logic clock, reset;
   logic req_valid, req_stall, req_operation;
   logic [4:0] req_coefficient_index;
   logic signed [47:0] req_coefficient_value;
   logic signed [31:0] req_pixel_x, req_pixel_y;
   logic rsp_valid, rsp_stall;
   logic signed [31:0] rsp_world_x, rsp_world_y;
   logic [1:0] rsp_status;

   longint calib[DEPTH];
   world_pt_t pending_pts[$];
   bit sat_flag;
   bit quiet;
   int mismatches;
   int idle_cycles;

   lens_undistort_homography_core dut (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [63:0] mag(longint a);
      return a < 0 ? -a : a;
   endfunction

   function automatic longint clip_mag(bit neg, logic [127:0] m);
      if (m > MAXV) begin
         sat_flag = 1'b1;
         m = MAXV;
      end
      return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
   endfunction

   function automatic longint q_add(longint a, longint b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'(MAXV)) begin
         sat_flag = 1'b1;
         return MAXV;
      end
      if (s < -65'(MAXV)) begin
         sat_flag = 1'b1;
         return -MAXV;
      end
      return longint'(s);
   endfunction

   function automatic longint q_mul(longint a, longint b);
      logic [127:0] m;
      m = {64'b0, mag(a)} * {64'b0, mag(b)};
      m = (m + 128'h8000_0000) >> 32;
      return clip_mag((a < 0) != (b < 0), m);
   endfunction

   function automatic longint q_div(longint a, longint b);
      logic [127:0] num, q, r;
      num = {32'b0, mag(a), 32'b0};
      q = num / {64'b0, mag(b)};
      r = num % {64'b0, mag(b)};
      if (q > MAXV) begin
         sat_flag = 1'b1;
         q = MAXV;
      end else if ((r << 1) >= {64'b0, mag(b)}) begin
         q = q + 1;
      end
      return clip_mag((a < 0) != (b < 0), q);
   endfunction

   function automatic logic [31:0] to_q16(longint v);
      logic [63:0] m, r;
      m = mag(v);
      r = (m >> 16) + ((m >> 15) & 64'd1);
      if (v >= 0 && r > 64'h7FFF_FFFF) begin
         sat_flag = 1'b1;
         r = 64'h7FFF_FFFF;
      end
      if (v < 0 && r > 64'h8000_0000) begin
         sat_flag = 1'b1;
         r = 64'h8000_0000;
      end
      return v < 0 ? 32'(-r) : 32'(r);
   endfunction

   function automatic world_pt_t undistort_map(logic signed [31:0] px, logic signed [31:0] py);
      world_pt_t res;
      longint xd0, xd1, x0, x1, sq0, sq1, r2, r4, r6, kr, pxy, txy, d0, d1, u, v, s, nx, ny;
      res = '0;
      res.status = ST_DIVZERO;
      sat_flag = 1'b0;
      if (calib[2] == 0 || calib[3] == 0) return res;
      xd0 = q_div(q_add(longint'(px) <<< 16, -calib[0]), calib[2]);
      xd1 = q_div(q_add(longint'(py) <<< 16, -calib[1]), calib[3]);
      x0 = xd0;
      x1 = xd1;
      for (int i = 0; i < ITERS; i++) begin
         sq0 = q_mul(x0, x0);
         sq1 = q_mul(x1, x1);
         r2 = q_add(sq0, sq1);
         r4 = q_mul(r2, r2);
         r6 = q_mul(r4, r2);
         kr = q_add(q_add(ONE, q_mul(calib[4], r2)),
                    q_add(q_mul(calib[5], r4), q_mul(calib[8], r6)));
         pxy = q_mul(x0, x1);
         txy = q_add(pxy, pxy);
         d0 = q_add(q_mul(calib[6], txy), q_mul(calib[7], q_add(r2, q_add(sq0, sq0))));
         d1 = q_add(q_mul(calib[6], q_add(r2, q_add(sq1, sq1))), q_mul(calib[7], txy));
         if (kr == 0) return res;
         x0 = q_div(q_add(xd0, -d0), kr);
         x1 = q_div(q_add(xd1, -d1), kr);
      end
      u = q_add(q_mul(x0, calib[2]), calib[0]);
      v = q_add(q_mul(x1, calib[3]), calib[1]);
      s = q_add(q_add(q_mul(calib[15], u), q_mul(calib[16], v)), calib[17]);
      if (s == 0) return res;
      nx = q_add(q_add(q_mul(calib[9], u), q_mul(calib[10], v)), calib[11]);
      ny = q_add(q_add(q_mul(calib[12], u), q_mul(calib[13], v)), calib[14]);
      res.wx = to_q16(q_div(nx, s));
      res.wy = to_q16(q_div(ny, s));
      res.status = ST_OK;
      if (sat_flag) res.status = ST_SAT;
      return res;
   endfunction

   // ---------------------------------------------------------------- driving
   // called at a falling edge; returns at the falling edge after the beat
   task automatic send_beat(logic op, logic [4:0] idx, logic signed [47:0] val,
                            logic signed [31:0] px, logic signed [31:0] py);
      while (!quiet && $urandom_range(99) < 38) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_operation = op;
      req_coefficient_index = idx;
      req_coefficient_value = val;
      req_pixel_x = px;
      req_pixel_y = py;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      if (op == OPC_WRITE) begin
         if (idx < DEPTH) calib[idx] = longint'(val);
      end else begin
         pending_pts.push_back(undistort_map(px, py));
      end
      @(negedge clock);
   endtask

   task automatic write_coef(logic [4:0] idx, logic signed [47:0] val);
      send_beat(OPC_WRITE, idx, val, 32'($urandom), 32'($urandom));
   endtask

   task automatic map_point(logic signed [31:0] px, logic signed [31:0] py);
      send_beat(OPC_XFORM, 5'($urandom), 48'({$urandom, $urandom}), px, py);
   endtask

   task automatic wait_drain();
      req_valid = 1'b0;
      while (pending_pts.size() != 0) @(negedge clock);
   endtask

   // plausible calibration value for one store entry
   function automatic logic signed [47:0] plausible_coef(logic [4:0] idx);
      longint c;
      case (idx)
         IX_CX, IX_CY: c = longint'($urandom_range(2000)) <<< 32;
         IX_FX, IX_FY: c = longint'($urandom_range(1500, 200)) <<< 32;
         5'd4, 5'd5, 5'd6, 5'd7, IX_K3: c = longint'($signed($urandom)) >>> 4;
         default: c = longint'($signed($urandom)) <<< 2;
      endcase
      return c[47:0];
   endfunction

   // ---------------------------------------------------------------- tests
   task automatic test_empty_store();
      // everything zero: focal length zero
      map_point(32'sd100 <<< 16, 32'sd50 <<< 16);
   endtask

   task automatic test_identity();
      for (int i = 0; i < DEPTH; i++) write_coef(5'(i), 48'sd0);
      write_coef(IX_FX, 48'(ONE));
      write_coef(IX_FY, 48'(ONE));
      write_coef(IX_H00, 48'(ONE));
      write_coef(IX_H11, 48'(ONE));
      write_coef(IX_H22, 48'(ONE));
      map_point(32'sd3 <<< 16, -32'sd7 <<< 15);
      map_point(32'sh7FFF_FFFF, 32'sh8000_0000);
      map_point(32'sd0, 32'sd0);
   endtask

   task automatic test_radial_zero();
      // k1 = -1 and r^2 = 1 gives a zero radial factor
      write_coef(IX_K1, -48'(ONE));
      map_point(32'sd1 <<< 16, 32'sd0);
      write_coef(IX_K1, 48'sd0);
   endtask

   task automatic test_scale_zero();
      write_coef(IX_H22, 48'sd0);
      map_point(32'sd0, 32'sd0);
      write_coef(IX_H22, 48'(ONE));
   endtask

   task automatic test_saturation();
      write_coef(IX_H00, 48'sh7FFF_FFFF_FFFF);
      write_coef(IX_H22, 48'sd1);
      map_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      write_coef(IX_H00, 48'sh8000_0000_0000);
      map_point(32'sh7FFF_FFFF, -32'sd1);
      write_coef(IX_H00, 48'(ONE));
      write_coef(IX_H22, 48'(ONE));
   endtask

   task automatic test_index_range();
      // writes above the store are dropped
      write_coef(5'd18, 48'sh7FFF_FFFF_FFFF);
      write_coef(5'd31, 48'sh8000_0000_0000);
      map_point(32'sd5 <<< 16, 32'sd9 <<< 16);
   endtask

   task automatic test_random(int n_items);
      logic [4:0] idx;
      for (int i = 0; i < n_items; i++) begin
         quiet = (i >= n_items / 3 && i < n_items / 2);
         if (i == n_items / 2) wait_drain();
         if ($urandom_range(99) < 15) begin
            if ($urandom_range(99) < 80)
               map_point(32'($urandom_range(2000 << 16)), 32'($urandom_range(2000 << 16)));
            else
               map_point(32'($urandom), 32'($urandom));
         end else if ($urandom_range(99) < 85) begin
            idx = 5'($urandom_range(DEPTH - 1));
            write_coef(idx, plausible_coef(idx));
         end else begin
            write_coef(5'($urandom), 48'({$urandom, $urandom}));
         end
      end
      quiet = 1'b0;
   endtask

   // ---------------------------------------------------------------- result side
   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 38);
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_pts.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result beat %h %h %0d",
                                              rsp_world_x, rsp_world_y, rsp_status);
            end else begin
               world_pt_t want;
               want = pending_pts.pop_front();
               if (want.wx !== rsp_world_x || want.wy !== rsp_world_y
                   || want.status !== rsp_status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %h %h %0d, got %h %h %0d",
                              want.wx, want.wy, want.status,
                              rsp_world_x, rsp_world_y, rsp_status);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      reset = 1'b1;
      quiet = 1'b0;
      mismatches = 0;
      rsp_stall = 1'b0;
      req_valid = 1'b0;
      req_operation = OPC_XFORM;
      req_coefficient_index = '0;
      req_coefficient_value = '0;
      req_pixel_x = '0;
      req_pixel_y = '0;
      for (int i = 0; i < DEPTH; i++) calib[i] = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_empty_store();
      test_identity();
      test_radial_zero();
      test_scale_zero();
      test_saturation();
      test_index_range();
      test_random(950);
      wait_drain();
      repeat (200) @(negedge clock);
      if (mismatches == 0 && pending_pts.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/luh_pkg.sv
rtl/luh_ram.sv
rtl/luh_mul.sv
rtl/luh_div.sv
rtl/luh_datapath.sv
rtl/luh_ctrl.sv
rtl/lens_undistort_homography_core.sv
verif/lens_undistort_homography_core_tb.sv
